// ===== rtl/kfee_pkg.sv =====
package kfee_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned EXCH_W     = 8;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned FEE_W      = 16;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned IN_DATA_W  = 168;
  localparam int unsigned OUT_DATA_W = 96;

  typedef enum logic [CMD_W-1:0] {
    CMD_UPDATE = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2
  } kfee_cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 3'd0,
    ST_NOT_FOUND    = 3'd1,
    ST_STALE        = 3'd2,
    ST_EMPTY        = 3'd3,
    ST_BAD_EXCHANGE = 3'd4,
    ST_FULL         = 3'd5
  } kfee_status_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [EXCH_W-1:0] exch;
    logic [KEY_W-1:0]  key;
    logic [FEE_W-1:0]  maker;
    logic [FEE_W-1:0]  taker;
    logic [TIME_W-1:0] stamp;
  } kfee_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [FEE_W-1:0]  maker;
    logic [FEE_W-1:0]  taker;
    logic [TIME_W-1:0] stamp;
  } kfee_res_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [FEE_W-1:0]  maker;
    logic [FEE_W-1:0]  taker;
    logic [TIME_W-1:0] stamp;
  } kfee_entry_t;

  typedef struct packed {
    logic [FEE_W-1:0]  maker;
    logic [FEE_W-1:0]  taker;
    logic [TIME_W-1:0] stamp;
  } kfee_slot_t;

endpackage

// ===== rtl/kfee_ram.sv =====
module kfee_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/kfee_ctrl.sv =====
module kfee_ctrl import kfee_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES  = 64,
  parameter int unsigned EXCHANGE_SLOTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  kfee_req_t         req_i,
  input  logic [TIME_W-1:0] limit_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output kfee_res_t         res_o
);

  localparam int unsigned EntAw  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned ScanCw = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned SlotAw = (EXCHANGE_SLOTS > 1) ? $clog2(EXCHANGE_SLOTS) : 1;
  localparam int unsigned ClrN   = (TABLE_ENTRIES > EXCHANGE_SLOTS) ? TABLE_ENTRIES
                                                                    : EXCHANGE_SLOTS;
  localparam int unsigned ClrCw  = $clog2(ClrN + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_SLOT_RD,
    S_SLOT_CHK,
    S_EMIT
  } state_e;

  state_e              state_q, state_d;
  kfee_req_t           req_q, req_d;
  kfee_res_t           res_q, res_d;
  logic [ClrCw-1:0]    clr_q, clr_d;
  logic [ScanCw-1:0]   scan_q, scan_d;
  logic                rd_pend_q, rd_pend_d;
  logic [EntAw-1:0]    rd_idx_q, rd_idx_d;
  logic                hit_q, hit_d;
  logic [EntAw-1:0]    hit_idx_q, hit_idx_d;
  logic                free_q, free_d;
  logic [EntAw-1:0]    free_idx_q, free_idx_d;
  logic [FEE_W-1:0]    hit_mk_q, hit_mk_d;
  logic [FEE_W-1:0]    hit_tk_q, hit_tk_d;
  logic [TIME_W-1:0]   hit_time_q, hit_time_d;

  logic                ent_we, ent_re;
  logic [EntAw-1:0]    ent_waddr, ent_raddr;
  kfee_entry_t         ent_wdata, ent_rdata;
  logic                slot_we, slot_re;
  logic [SlotAw-1:0]   slot_addr;
  kfee_slot_t          slot_wdata, slot_rdata;

  logic                exch_ok;
  logic [TIME_W-1:0]   ent_age, slot_age;

  assign exch_ok   = ({1'b0, req_q.exch} < (EXCH_W + 1)'(EXCHANGE_SLOTS));
  assign slot_addr = (state_q == S_CLEAR) ? clr_q[SlotAw-1:0] : req_q.exch[SlotAw-1:0];
  assign ent_age   = req_q.stamp - hit_time_q;
  assign slot_age  = req_q.stamp - slot_rdata.stamp;

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    res_d      = res_q;
    clr_d      = clr_q;
    scan_d     = scan_q;
    rd_pend_d  = 1'b0;
    rd_idx_d   = rd_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    hit_mk_d   = hit_mk_q;
    hit_tk_d   = hit_tk_q;
    hit_time_d = hit_time_q;

    ent_we     = 1'b0;
    ent_waddr  = hit_idx_q;
    ent_wdata  = '0;
    ent_re     = 1'b0;
    ent_raddr  = scan_q[EntAw-1:0];
    slot_we    = 1'b0;
    slot_wdata = '0;
    slot_re    = 1'b0;

    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_CLEAR: begin
        ent_we    = (clr_q < ClrCw'(TABLE_ENTRIES));
        ent_waddr = clr_q[EntAw-1:0];
        slot_we   = (clr_q < ClrCw'(EXCHANGE_SLOTS));
        if (clr_q == ClrCw'(ClrN - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + ClrCw'(1);
        end
      end

      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d  = req_i;
          res_d  = '0;
          scan_d = '0;
          hit_d  = 1'b0;
          free_d = 1'b0;
          case (kfee_cmd_e'(req_i.cmd))
            CMD_UPDATE, CMD_LOOKUP: begin
              state_d = (req_i.key == '0) ? S_SLOT_RD : S_SCAN;
            end
            CMD_REMOVE: begin
              if (req_i.key == '0) begin
                res_d.status = ST_NOT_FOUND;
                state_d      = S_EMIT;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
              res_d.status = ST_OK;
              state_d      = S_EMIT;
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue the next read while checking the one that just returned
        if (scan_q != ScanCw'(TABLE_ENTRIES)) begin
          ent_re    = 1'b1;
          rd_pend_d = 1'b1;
          rd_idx_d  = scan_q[EntAw-1:0];
          scan_d    = scan_q + ScanCw'(1);
        end
        if (rd_pend_q) begin
          if (ent_rdata.valid && (ent_rdata.key == req_q.key)) begin
            hit_d      = 1'b1;
            hit_idx_d  = rd_idx_q;
            hit_mk_d   = ent_rdata.maker;
            hit_tk_d   = ent_rdata.taker;
            hit_time_d = ent_rdata.stamp;
            state_d    = S_ACT;
          end else begin
            if (!ent_rdata.valid && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = rd_idx_q;
            end
            if (rd_idx_q == EntAw'(TABLE_ENTRIES - 1)) begin
              state_d = S_ACT;
            end
          end
        end
      end

      S_ACT: begin
        state_d = S_EMIT;
        case (kfee_cmd_e'(req_q.cmd))
          CMD_UPDATE: begin
            ent_wdata.valid = 1'b1;
            ent_wdata.key   = req_q.key;
            ent_wdata.maker = req_q.maker;
            ent_wdata.taker = req_q.taker;
            ent_wdata.stamp = req_q.stamp;
            if (hit_q) begin
              ent_we       = 1'b1;
              res_d.status = ST_OK;
            end else if (free_q) begin
              ent_we       = 1'b1;
              ent_waddr    = free_idx_q;
              res_d.status = ST_OK;
            end else begin
              res_d.status = ST_FULL;
            end
          end
          CMD_REMOVE: begin
            ent_we       = hit_q;
            res_d.status = hit_q ? ST_OK : ST_NOT_FOUND;
          end
          CMD_LOOKUP: begin
            if (!hit_q) begin
              state_d = S_SLOT_RD;
            end else if (ent_age <= limit_i) begin
              res_d.status = ST_OK;
              res_d.maker  = hit_mk_q;
              res_d.taker  = hit_tk_q;
              res_d.stamp  = hit_time_q;
            end else begin
              res_d.status = ST_STALE;
            end
          end
          default: begin
            res_d.status = ST_OK;
          end
        endcase
      end

      S_SLOT_RD: begin
        if (!exch_ok) begin
          res_d.status = ST_BAD_EXCHANGE;
          state_d      = S_EMIT;
        end else if (kfee_cmd_e'(req_q.cmd) == CMD_UPDATE) begin
          slot_we          = 1'b1;
          slot_wdata.maker = req_q.maker;
          slot_wdata.taker = req_q.taker;
          slot_wdata.stamp = req_q.stamp;
          res_d.status     = ST_OK;
          state_d          = S_EMIT;
        end else begin
          slot_re = 1'b1;
          state_d = S_SLOT_CHK;
        end
      end

      S_SLOT_CHK: begin
        state_d = S_EMIT;
        if (slot_rdata.stamp == '0) begin
          res_d.status = ST_EMPTY;
        end else if (slot_age > limit_i) begin
          res_d.status = ST_STALE;
        end else begin
          res_d.status = ST_OK;
          res_d.maker  = slot_rdata.maker;
          res_d.taker  = slot_rdata.taker;
          res_d.stamp  = slot_rdata.stamp;
        end
      end

      S_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      req_q      <= '0;
      res_q      <= '0;
      clr_q      <= '0;
      scan_q     <= '0;
      rd_pend_q  <= 1'b0;
      rd_idx_q   <= '0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      free_q     <= 1'b0;
      free_idx_q <= '0;
      hit_mk_q   <= '0;
      hit_tk_q   <= '0;
      hit_time_q <= '0;
    end else begin
      state_q    <= state_d;
      req_q      <= req_d;
      res_q      <= res_d;
      clr_q      <= clr_d;
      scan_q     <= scan_d;
      rd_pend_q  <= rd_pend_d;
      rd_idx_q   <= rd_idx_d;
      hit_q      <= hit_d;
      hit_idx_q  <= hit_idx_d;
      free_q     <= free_d;
      free_idx_q <= free_idx_d;
      hit_mk_q   <= hit_mk_d;
      hit_tk_q   <= hit_tk_d;
      hit_time_q <= hit_time_d;
    end
  end

  assign res_o = res_q;

  kfee_ram #(
    .WIDTH ($bits(kfee_entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  kfee_ram #(
    .WIDTH ($bits(kfee_slot_t)),
    .DEPTH (EXCHANGE_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_addr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_addr),
    .rdata_o (slot_rdata)
  );

endmodule

// ===== rtl/keyed_fee_table_with_fallback_core.sv =====
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+----------------------------------------
// s_axis    | in        | tvalid / tready        | tuser: command; tdata: request fields
// m_axis    | out       | tvalid / tready        | tuser: status; tdata: found fee fields
// cfg       | in        | cfg_we_i               | cfg_wdata_i: staleness limit
//
// One request at a time. A nonzero key walks the entry memory one entry per cycle, and a
// lookup that misses there falls back to the exchange slot; key 0 updates and lookups use
// the exchange slot alone, and a remove of key 0 or the unused command is answered without
// touching either memory. After reset a clearing pass zeroes both memories; no request is
// taken meanwhile.
// The result register lets the next request enter while a result waits on m_axis.
module keyed_fee_table_with_fallback_core import kfee_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES  = 64,
  parameter int unsigned EXCHANGE_SLOTS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // exchange_number, instrument_key, maker_fee, taker_fee, time_value
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // command
  input  logic [CMD_W-1:0]      s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // found_maker_fee, found_taker_fee, found_time
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // status
  output logic [STAT_W-1:0]     m_axis_tuser_o,
  input  logic                  cfg_we_i,
  input  logic [TIME_W-1:0]     cfg_wdata_i
);

  logic [TIME_W-1:0] limit_q;
  kfee_req_t         req;
  kfee_res_t         res;
  logic              res_valid, res_ready;
  logic              out_valid_q;
  kfee_res_t         out_q;
  logic              req_pend_q;
  logic              s_acc, res_hs;

  assign req.cmd   = s_axis_tuser_i;
  assign req.exch  = s_axis_tdata_i[7:0];
  assign req.key   = s_axis_tdata_i[71:8];
  assign req.maker = s_axis_tdata_i[87:72];
  assign req.taker = s_axis_tdata_i[103:88];
  assign req.stamp = s_axis_tdata_i[167:104];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '1;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  kfee_ctrl #(
    .TABLE_ENTRIES  (TABLE_ENTRIES),
    .EXCHANGE_SLOTS (EXCHANGE_SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_i       (req),
    .limit_i     (limit_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // hold the result until the sink takes it
  assign res_ready = !out_valid_q || m_axis_tready_i;
  assign res_hs    = res_valid && res_ready;
  assign s_acc     = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
      if (res_valid) begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {out_q.stamp, out_q.taker, out_q.maker};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_pend_q <= 1'b0;
    end else if (s_acc) begin
      req_pend_q <= 1'b1;
    end else if (res_hs) begin
      req_pend_q <= 1'b0;
    end
  end

  a_no_accept_while_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |-> !req_pend_q)
    else $error("request accepted before previous result was produced");

  a_result_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_hs |-> req_pend_q)
    else $error("result produced without an outstanding request");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o <= ST_FULL))
    else $error("status code out of range");

  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != ST_OK)) |-> (m_axis_tdata_o == '0))
    else $error("found fields nonzero on a non-hit status");

endmodule
